[design/frcl_pkg.sv]
`timescale 1ns / 1ps
// Shared types, mode codes, register addresses, a saturating add and a max helper for the
// flow/row/column layout block. No dependencies.
package frcl_pkg;

	localparam int unsigned DimW  = 16;
	localparam int unsigned AddrW = 3;

	localparam logic [1:0] MODE_FLOW  = 2'd0;
	localparam logic [1:0] MODE_ROW   = 2'd1;
	localparam logic [1:0] MODE_COL   = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic REG_LAYOUT_MODE = 1'b0;
	localparam logic REG_INNER_WIDTH = 1'b1;

	typedef logic [DimW-1:0] dim_t;

	typedef struct packed {
		dim_t child_width;
		dim_t child_height;
		logic is_absolute;
		logic is_last_child;
	} item_t;

	typedef struct packed {
		dim_t offset_x;
		dim_t offset_y;
		dim_t used_width;
		dim_t used_height;
		logic is_final;
	} result_t;

	typedef struct packed {
		dim_t cursor_x;
		dim_t cursor_y;
		dim_t line_height;
		dim_t extent_width;
		dim_t extent_height;
	} state_t;

	function automatic dim_t sat_add(input dim_t a, input dim_t b);
		logic [DimW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DimW] ? {DimW{1'b1}} : s[DimW-1:0];
	endfunction

	function automatic dim_t max_dim(input dim_t a, input dim_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

[design/frcl_step.sv]
`timescale 1ns / 1ps
// Placement of one child against the running layout state: offset, next state
// and running content size. Depends on frcl_pkg.
module frcl_step (
	input  frcl_pkg::item_t   item,
	input  frcl_pkg::state_t  cur,
	input  logic [1:0]        layout_mode,
	input  frcl_pkg::dim_t    inner_width,
	output frcl_pkg::state_t  nxt,
	output frcl_pkg::result_t res
);
	import frcl_pkg::*;

	logic [DimW:0] reach;
	logic          wrap;
	dim_t          flow_cx;
	dim_t          flow_cy;
	dim_t          flow_lh;
	state_t        placed;
	state_t        upd;
	logic          flow;
	dim_t          ox;
	dim_t          oy;

	always_comb begin
		reach   = {1'b0, cur.cursor_x} + {1'b0, item.child_width};
		wrap    = reach > {1'b0, inner_width};
		flow_cx = wrap ? '0 : cur.cursor_x;
		flow_lh = wrap ? '0 : cur.line_height;
		flow_cy = (wrap && (cur.cursor_x != '0)) ? sat_add(cur.cursor_y, cur.line_height)
			: cur.cursor_y;
	end

	always_comb begin
		placed = cur;
		flow   = 1'b0;
		ox     = cur.cursor_x;
		oy     = cur.cursor_y;
		case (layout_mode)
			MODE_ROW: begin
				placed.cursor_y      = sat_add(cur.cursor_y, item.child_height);
				placed.extent_height = sat_add(cur.extent_height, item.child_height);
				placed.extent_width  = max_dim(cur.extent_width, item.child_width);
			end
			MODE_COL: begin
				placed.cursor_x      = sat_add(cur.cursor_x, item.child_width);
				placed.extent_width  = sat_add(cur.extent_width, item.child_width);
				placed.extent_height = max_dim(cur.extent_height, item.child_height);
			end
			default: begin
				flow                 = 1'b1;
				ox                   = flow_cx;
				oy                   = flow_cy;
				placed.cursor_x      = sat_add(flow_cx, item.child_width);
				placed.cursor_y      = flow_cy;
				placed.line_height   = max_dim(flow_lh, item.child_height);
				placed.extent_width  = max_dim(cur.extent_width, placed.cursor_x);
				placed.extent_height = max_dim(cur.extent_height, flow_cy);
			end
		endcase
	end

	always_comb begin
		upd = item.is_absolute ? cur : placed;
		res.offset_x    = item.is_absolute ? '0 : ox;
		res.offset_y    = item.is_absolute ? '0 : oy;
		res.used_width  = upd.extent_width;
		res.used_height = flow ? sat_add(upd.extent_height, upd.line_height)
			: upd.extent_height;
		res.is_final    = item.is_last_child;
		nxt = item.is_last_child ? '0 : upd;
	end

endmodule

[design/flow_row_column_layout.sv]
`timescale 1ns / 1ps
// Top level of the flow/row/column child layout block: input stage, layout
// state, result stage and register port. Depends on frcl_pkg and frcl_step.
//
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       tdata width,height; tuser absolute; tlast last
// m_*       out  m_tvalid / m_tready       tdata offsets, content size; tlast final
// APB       in   psel, penable, pwrite     layout_mode at 0x0, container_inner_width at 0x4
//
// One child per cycle sustained while the output is not stalled; results pass through
// the input and result stages, and the loop through the layout state sets that rate.
// Reset sets flow mode and all-ones inner width, clears layout state and both valids.
// A stalled output holds the result stage; an empty input stage takes one more child.
module flow_row_column_layout (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // child_width, child_height
	input  logic                       s_tuser,   // is_absolute
	input  logic                       s_tlast,   // is_last_child
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [63:0]                m_tdata,   // offset_x, offset_y, used_width, used_height
	output logic                       m_tlast,   // is_final
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [frcl_pkg::AddrW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import frcl_pkg::*;

	logic [1:0] layout_mode_q;
	dim_t       inner_width_q;
	state_t     state_q;
	state_t     state_nxt;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_comb;
	result_t    result_s2;
	logic       valid_s2;
	logic       adv_s1;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_mode_q <= MODE_FLOW;
			inner_width_q <= '1;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_LAYOUT_MODE: layout_mode_q <= pwdata[1:0];
				REG_INNER_WIDTH: inner_width_q <= pwdata[DimW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LAYOUT_MODE: prdata = {30'd0, layout_mode_q};
			REG_INNER_WIDTH: prdata = {16'd0, inner_width_q};
			default:         prdata = '0;
		endcase
	end

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{child_width: s_tdata[15:0], child_height: s_tdata[31:16],
				is_absolute: s_tuser, is_last_child: s_tlast};
		end
	end

	frcl_step u_step (
		.item        (item_s1),
		.cur         (state_q),
		.layout_mode (layout_mode_q),
		.inner_width (inner_width_q),
		.nxt         (state_nxt),
		.res         (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {result_s2.used_height, result_s2.used_width,
		result_s2.offset_y, result_s2.offset_x};
	assign m_tlast  = result_s2.is_final;

endmodule

[design/frcl_chk.sv]
`timescale 1ns / 1ps
// Port-level checks for flow_row_column_layout and the bind that attaches them.
// Depends on frcl_pkg and the top level's ports.
module frcl_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [63:0]                m_tdata,
	input logic                       m_tlast,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [frcl_pkg::AddrW-1:0] paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata
);
	import frcl_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_full_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input held off with the result stage free");

	a_mode_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == {REG_LAYOUT_MODE, 2'b00}
		|=> (paddr != {REG_LAYOUT_MODE, 2'b00}) || (psel && penable && pwrite)
			|| prdata[1:0] == $past(pwdata[1:0]))
		else $error("layout mode readback mismatch");

endmodule

bind flow_row_column_layout frcl_chk u_frcl_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);
